/* sv/ifl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Index free-list pool allocator package
// Request and response payloads, status codes, register indexes and the
// controller state type shared by the allocator core and its parts.
// ----------------------------------------------------------------------------
package ifl_pkg;

   localparam int unsigned CSR_INDEX_W  = 2;
   localparam int unsigned CSR_DATA_W   = 16;
   localparam int unsigned BLOCKS_W     = 11;
   localparam int unsigned BYTES_W      = 16;
   localparam int unsigned ALIGN_W      = 13;
   localparam int unsigned STRIDE_W     = 17;
   localparam int unsigned INDEX_W      = 10;
   localparam int unsigned OFFSET_W     = 26;
   localparam int unsigned STATUS_W     = 2;

   localparam logic [ALIGN_W-1:0]  ALIGN_MAX          = 13'd4096;
   localparam logic [BLOCKS_W-1:0] BLOCKS_RESET       = 11'd1024;
   localparam logic [BYTES_W-1:0]  BLOCK_BYTES_RESET  = 16'd8;
   localparam logic [ALIGN_W-1:0]  ALIGN_BYTES_RESET  = 13'd8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BLOCKS_IN_USE = 2'd0,
      CSR_BLOCK_BYTES   = 2'd1,
      CSR_ALIGN_BYTES   = 2'd2
   } csr_index_type;

   typedef enum logic {
      REQ_ALLOC = 1'b0,
      REQ_FREE  = 1'b1
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK           = 2'd0,
      STATUS_POOL_EMPTY   = 2'd1,
      STATUS_FREE_REFUSED = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_INIT,
      ST_IDLE,
      ST_LOAD
   } state_type;

   typedef struct packed {
      logic               req_type;
      logic [INDEX_W-1:0] free_index;
   } ifl_req_type;

   typedef struct packed {
      logic [INDEX_W-1:0]  block_index;
      logic [OFFSET_W-1:0] byte_offset;
      logic [STATUS_W-1:0] status;
      logic [BLOCKS_W-1:0] free_count;
   } ifl_rsp_type;

   typedef struct packed {
      logic               start;
      logic [BYTES_W-1:0] block_bytes;
      logic [ALIGN_W-1:0] align_bytes;
   } stride_ctrl_type;

   typedef struct packed {
      logic                busy;
      logic [STRIDE_W-1:0] stride;
   } stride_stat_type;

endpackage

/* sv/ifl_stride.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block stride unit
// Rounds the block size up to a multiple of the alignment with a restoring
// remainder loop, one numerator bit per cycle: stride = n - (n mod a),
// where n = size + a - 1.
// ----------------------------------------------------------------------------
module ifl_stride (
   input  logic                     clock,
   input  logic                     reset,
   input  ifl_pkg::stride_ctrl_type ctrl,
   output ifl_pkg::stride_stat_type stat
);
   import ifl_pkg::*;

   localparam int unsigned CNT_W = $clog2(STRIDE_W + 1);

   logic [ALIGN_W-1:0]  align_ff, align_in;
   logic [STRIDE_W-1:0] num_ff, num_in;
   logic [STRIDE_W-1:0] shift_ff, shift_in;
   logic [ALIGN_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic [STRIDE_W-1:0] stride_ff, stride_in;

   logic [ALIGN_W-1:0]  align_eff;
   logic [ALIGN_W:0]    trial;

   always_comb begin
      align_eff = ctrl.align_bytes;
      if (ctrl.align_bytes == '0) begin
         align_eff = ALIGN_W'(1);
      end else if (ctrl.align_bytes > ALIGN_MAX) begin
         align_eff = ALIGN_MAX;
      end
   end

   assign trial = {rem_ff, shift_ff[STRIDE_W-1]};

   always_comb begin
      align_in  = align_ff;
      num_in    = num_ff;
      shift_in  = shift_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      stride_in = stride_ff;
      if (ctrl.start) begin
         align_in = align_eff;
         num_in   = STRIDE_W'(ctrl.block_bytes) + STRIDE_W'(align_eff) - STRIDE_W'(1);
         shift_in = STRIDE_W'(ctrl.block_bytes) + STRIDE_W'(align_eff) - STRIDE_W'(1);
         rem_in   = '0;
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff == CNT_W'(STRIDE_W)) begin
            stride_in = num_ff - STRIDE_W'(rem_ff);
            busy_in   = 1'b0;
         end else begin
            if (trial >= {1'b0, align_ff}) begin
               rem_in = ALIGN_W'(trial - {1'b0, align_ff});
            end else begin
               rem_in = ALIGN_W'(trial);
            end
            shift_in = {shift_ff[STRIDE_W-2:0], 1'b0};
            cnt_in   = cnt_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      align_ff  <= align_in;
      num_ff    <= num_in;
      shift_ff  <= shift_in;
      rem_ff    <= rem_in;
      stride_ff <= stride_in;
   end

   assign stat.busy   = busy_ff;
   assign stat.stride = stride_ff;

endmodule

/* sv/index_free_list_pool_allocator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Index free-list pool allocator core
// Pool of equal blocks kept as a linked free list of block indices in a
// single-port-write, single-port-read link memory with registered read.
// ----------------------------------------------------------------------------
// An allocate request holds off the next request, unlike a free, since the
// pop reads the head's link from the link memory before the next request may
// use the new head; a result waits in an output register while the next
// request is taken. After reset and after every write to a known register
// the block runs an initialization pass that writes each link memory entry
// once. The pass runs until the last entry is written and the stride
// division has finished, and the block takes no request until it ends.
// Refused requests (pool empty, free into a full pool, free index out of
// range) return a status code and leave the pool unchanged.
module index_free_list_pool_allocator_core #(
   parameter int unsigned POOL_DEPTH = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  ifl_pkg::ifl_req_type                 req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output ifl_pkg::ifl_rsp_type                 rsp_data,
   input  logic                                 csr_write_enable,
   input  logic [ifl_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [ifl_pkg::CSR_DATA_W-1:0]       csr_write_data
);
   import ifl_pkg::*;

   localparam int unsigned ADDR_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int unsigned LINK_W = $clog2(POOL_DEPTH + 1);
   localparam int unsigned PROD_W = ADDR_W + STRIDE_W;
   localparam logic [LINK_W-1:0] DEPTH_LINK = LINK_W'(POOL_DEPTH);
   localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(POOL_DEPTH - 1);

   logic [LINK_W-1:0] link_mem [POOL_DEPTH];
   logic [LINK_W-1:0] rdata_ff;

   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   init_addr_ff, init_addr_in;
   logic                init_start_ff, init_start_in;
   logic [LINK_W-1:0]   head_ff, head_in;
   logic [BLOCKS_W-1:0] free_ff, free_in;
   logic [BLOCKS_W-1:0] blocks_ff, blocks_in;
   logic [BYTES_W-1:0]  bytes_ff, bytes_in;
   logic [ALIGN_W-1:0]  align_ff, align_in;
   ifl_rsp_type         pend_ff, pend_in;
   logic                pend_valid_ff, pend_valid_in;
   ifl_rsp_type         rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                mem_we, mem_re;
   logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
   logic [LINK_W-1:0]   mem_wdata;

   stride_ctrl_type     stride_ctrl;
   stride_stat_type     stride_stat;

   logic                csr_hit;
   logic                accept;
   logic                out_free;
   logic                init_last;
   logic                init_exit;
   logic [BLOCKS_W-1:0] n_eff;
   logic [ADDR_W-1:0]   head_addr;
   logic [ADDR_W-1:0]   idx_addr;
   logic [PROD_W-1:0]   prod;
   logic                free_bad;

   ifl_stride u_stride (
      .clock (clock),
      .reset (reset),
      .ctrl  (stride_ctrl),
      .stat  (stride_stat)
   );

   assign stride_ctrl.start       = init_start_ff;
   assign stride_ctrl.block_bytes = bytes_ff;
   assign stride_ctrl.align_bytes = align_ff;

   assign csr_hit   = csr_write_enable && (csr_index inside {CSR_BLOCKS_IN_USE,
                                                             CSR_BLOCK_BYTES,
                                                             CSR_ALIGN_BYTES});
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign init_last = (init_addr_ff == LAST_ADDR);
   assign init_exit = init_last && !stride_stat.busy && !init_start_ff;

   always_comb begin
      n_eff = blocks_ff;
      if (blocks_ff == '0) begin
         n_eff = BLOCKS_W'(1);
      end else if (32'(blocks_ff) > POOL_DEPTH) begin
         n_eff = BLOCKS_W'(POOL_DEPTH);
      end
   end

   assign head_addr = (head_ff >= DEPTH_LINK) ? '0 : ADDR_W'(head_ff);
   assign idx_addr  = ADDR_W'(req_data.free_index);
   assign prod      = PROD_W'(head_addr) * PROD_W'(stride_stat.stride);
   assign free_bad  = (free_ff >= n_eff) ||
                      (BLOCKS_W'(req_data.free_index) >= n_eff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (init_exit) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept && (req_data.req_type == REQ_ALLOC) && (free_ff != '0)) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: state_in = ST_IDLE;
         default: state_in = ST_INIT;
      endcase
      if (csr_hit) state_in = ST_INIT;
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: req_ready = !pend_valid_ff || out_free;
         default: req_ready = 1'b0;
      endcase
   end

   always_comb begin
      init_addr_in  = init_addr_ff;
      init_start_in = 1'b0;
      head_in       = head_ff;
      free_in       = free_ff;
      blocks_in     = blocks_ff;
      bytes_in      = bytes_ff;
      align_in      = align_ff;
      pend_in       = pend_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_waddr     = init_addr_ff;
      mem_raddr     = head_addr;
      mem_wdata     = LINK_W'(init_addr_ff) + LINK_W'(1);

      case (state_ff)
         ST_INIT: begin
            mem_we = 1'b1;
            if (!init_last) init_addr_in = init_addr_ff + ADDR_W'(1);
            if (init_exit) begin
               head_in = '0;
               free_in = n_eff;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               pend_in.block_index = '0;
               pend_in.byte_offset = '0;
               pend_in.status      = STATUS_OK;
               pend_in.free_count  = free_ff;
               if (req_data.req_type == REQ_ALLOC) begin
                  if (free_ff == '0) begin
                     pend_in.status = STATUS_POOL_EMPTY;
                  end else begin
                     mem_re              = 1'b1;
                     free_in             = free_ff - BLOCKS_W'(1);
                     pend_in.block_index = INDEX_W'(head_addr);
                     pend_in.byte_offset = OFFSET_W'(prod);
                     pend_in.free_count  = free_ff - BLOCKS_W'(1);
                  end
               end else begin
                  if (free_bad) begin
                     pend_in.status = STATUS_FREE_REFUSED;
                  end else begin
                     mem_we             = 1'b1;
                     mem_waddr          = idx_addr;
                     mem_wdata          = head_ff;
                     head_in            = LINK_W'(req_data.free_index);
                     free_in            = free_ff + BLOCKS_W'(1);
                     pend_in.free_count = free_ff + BLOCKS_W'(1);
                  end
               end
            end
         end
         ST_LOAD: head_in = rdata_ff;
         default: head_in = head_ff;
      endcase

      if (csr_hit) begin
         init_addr_in  = '0;
         init_start_in = 1'b1;
         case (csr_index)
            CSR_BLOCKS_IN_USE: blocks_in = BLOCKS_W'(csr_write_data);
            CSR_BLOCK_BYTES:   bytes_in  = BYTES_W'(csr_write_data);
            CSR_ALIGN_BYTES:   align_in  = ALIGN_W'(csr_write_data);
            default:           blocks_in = blocks_ff;
         endcase
      end
   end

   always_comb begin
      pend_valid_in = pend_valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      if (pend_valid_ff && out_free) begin
         rsp_in        = pend_ff;
         rsp_valid_in  = 1'b1;
         pend_valid_in = 1'b0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) pend_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= link_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         init_addr_ff  <= '0;
         init_start_ff <= 1'b1;
         head_ff       <= '0;
         free_ff       <= '0;
         blocks_ff     <= BLOCKS_RESET;
         bytes_ff      <= BLOCK_BYTES_RESET;
         align_ff      <= ALIGN_BYTES_RESET;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         init_addr_ff  <= init_addr_in;
         init_start_ff <= init_start_in;
         head_ff       <= head_in;
         free_ff       <= free_in;
         blocks_ff     <= blocks_in;
         bytes_ff      <= bytes_in;
         align_ff      <= align_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* sv/ifl_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Index free-list pool allocator port checker
// Watches the core's ports for status coding, pool-empty payloads, the
// initialization pass and response hold.
// ----------------------------------------------------------------------------
module ifl_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input ifl_pkg::ifl_rsp_type            rsp_data,
   input logic                            csr_write_enable,
   input logic [ifl_pkg::CSR_INDEX_W-1:0] csr_index
);
   import ifl_pkg::*;

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == STATUS_OK) ||
                    (rsp_data.status == STATUS_POOL_EMPTY) ||
                    (rsp_data.status == STATUS_FREE_REFUSED))
      else $error("response status out of range");

   a_empty_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == STATUS_POOL_EMPTY)) |->
         (rsp_data.free_count == '0) && (rsp_data.block_index == '0) &&
         (rsp_data.byte_offset == '0))
      else $error("pool empty response with nonzero payload");

   a_init_after_write: assert property (@(posedge clock) disable iff (reset)
      (csr_write_enable && ((csr_index == CSR_BLOCKS_IN_USE) ||
                            (csr_index == CSR_BLOCK_BYTES) ||
                            (csr_index == CSR_ALIGN_BYTES))) |=> !req_ready)
      else $error("request taken right after a register write");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response dropped or changed");

endmodule

bind index_free_list_pool_allocator_core ifl_checker u_ifl_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_data         (rsp_data),
   .csr_write_enable (csr_write_enable),
   .csr_index        (csr_index)
);
